// ----- hdl/epb_pkg.sv -----
// Shared types and constants of the extreme-point box placer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package epb_pkg;

    // width of a box or container extent field
    localparam int DIM_W = 7;
    // width of a corner coordinate in a result
    localparam int POS_W = 6;
    // width of the filled voxel count in a result
    localparam int FILL_W = 19;
    // width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // reset value of the container extents
    localparam logic [DIM_W-1:0] CONTAINER_RESET = 7'd64;

    typedef enum logic {
        OP_CLEAR = 1'b0,
        OP_PLACE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FIT    = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage
`default_nettype wire

// ----- hdl/epb_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on epb_pkg for the payload types.
`default_nettype none
interface epb_req_if;
    logic                        valid;
    logic                        ready;
    epb_pkg::op_t                operation;
    logic [epb_pkg::DIM_W-1:0]   box_length;
    logic [epb_pkg::DIM_W-1:0]   box_width;
    logic [epb_pkg::DIM_W-1:0]   box_height;

    modport source (output valid, operation, box_length, box_width, box_height,
                    input ready);
    modport sink   (input valid, operation, box_length, box_width, box_height,
                    output ready);
endinterface

interface epb_rsp_if;
    logic                        valid;
    logic                        ready;
    epb_pkg::status_t            status;
    logic [epb_pkg::POS_W-1:0]   pos_x;
    logic [epb_pkg::POS_W-1:0]   pos_y;
    logic [epb_pkg::POS_W-1:0]   pos_z;
    logic [epb_pkg::FILL_W-1:0]  filled_voxels;

    modport source (output valid, status, pos_x, pos_y, pos_z, filled_voxels,
                    input ready);
    modport sink   (input valid, status, pos_x, pos_y, pos_z, filled_voxels,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/epb_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module epb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- hdl/extreme_point_box_placer_unit.sv -----
// Extreme-point first-fit 3D box placer, top level.
// Reset and each clear request sweep the occupancy RAM, one z-row per cycle,
// over all GRID_DIM*GRID_DIM z-rows. A place request reads each stored point and
// tests it against the bounds and the best key so far; a point that passes has
// its corners read (4 grid RAM reads). The box is then written into the grid RAM
// by a read-modify-write per z-row of the box volume, then the points are updated.
// Async active-low reset restores 64^3 container and runs the sweep first.
`default_nettype none
module extreme_point_box_placer_unit #(
    parameter int GRID_DIM   = 64,
    parameter int MAX_POINTS = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [epb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [epb_pkg::DIM_W-1:0]         cfg_data,
    epb_req_if.sink                                req,
    epb_rsp_if.source                              rsp
);

    localparam int CW    = $clog2(GRID_DIM + 1);      // coordinate 0..GRID_DIM
    localparam int VW    = CW + 8;                    // room for coord + extent
    localparam int ZI    = $clog2(GRID_DIM);          // bit index in a z-row
    localparam int ROWS  = GRID_DIM * GRID_DIM;
    localparam int RAW   = $clog2(ROWS);
    localparam int PW    = 3 * CW;                    // {z, y, x}
    localparam int PIW   = $clog2(MAX_POINTS);
    localparam int PCW   = $clog2(MAX_POINTS + 1);
    localparam int FW    = $clog2(GRID_DIM * GRID_DIM * GRID_DIM + 1);
    localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PT_RD, S_PT_EVAL, S_CN_RD, S_CN_CHK, S_DECIDE,
        S_FL_RD, S_FL_WR, S_MV_RD, S_MV_CP, S_W1, S_W2, S_W3, S_DONE
    } state_t;

    state_t                       state_reg;
    logic                         rst_pass_reg;
    logic [RAW-1:0]               clr_idx_reg;
    logic [epb_pkg::DIM_W-1:0]    cfg_len_reg, cfg_wid_reg, cfg_hgt_reg;
    logic [CW-1:0]                l_reg, w_reg, h_reg;
    logic [PCW-1:0]               j_reg;
    logic [1:0]                   k_reg;
    logic [PW-1:0]                cand_reg;
    logic                         found_reg;
    logic [PIW-1:0]               best_idx_reg;
    logic [PW-1:0]                best_pt_reg;
    logic [PCW-1:0]               count_reg;
    logic [FW-1:0]                filled_reg;
    logic [CW-1:0]                fi_reg, fj_reg;
    logic [GRID_DIM-1:0]          mask_reg;
    epb_pkg::status_t             res_status_reg;
    logic                         out_valid_reg;
    epb_pkg::status_t             out_status_reg;
    logic [epb_pkg::POS_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic [epb_pkg::FILL_W-1:0]   out_fill_reg;

    // RAM ports
    logic                 g_we;
    logic [RAW-1:0]       g_waddr, g_raddr;
    logic [GRID_DIM-1:0]  g_wdata, g_rdata;
    logic                 p_we;
    logic [PIW-1:0]       p_waddr, p_raddr;
    logic [PW-1:0]        p_wdata, p_rdata;

    epb_ram #(.WIDTH(GRID_DIM), .DEPTH(ROWS)) u_grid (
        .clk(clk), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
        .rd_addr(g_raddr), .rd_data(g_rdata)
    );

    epb_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
        .clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
        .rd_addr(p_raddr), .rd_data(p_rdata)
    );

    // clamped container extents
    logic [VW-1:0] cl_v, cw_v, ch_v;
    assign cl_v = (VW'(cfg_len_reg) > VW'(GRID_DIM)) ? VW'(GRID_DIM) : VW'(cfg_len_reg);
    assign cw_v = (VW'(cfg_wid_reg) > VW'(GRID_DIM)) ? VW'(GRID_DIM) : VW'(cfg_wid_reg);
    assign ch_v = (VW'(cfg_hgt_reg) > VW'(GRID_DIM)) ? VW'(GRID_DIM) : VW'(cfg_hgt_reg);

    // request size check
    logic too_large;
    assign too_large = (req.box_length == '0) || (req.box_width == '0) ||
                       (req.box_height == '0) ||
                       (VW'(req.box_length) > cl_v) || (VW'(req.box_width) > cw_v) ||
                       (VW'(req.box_height) > ch_v);

    // fields of the point just read and of the candidate
    logic [CW-1:0] rp_x, rp_y, rp_z, c_x, c_y, c_z, b_x, b_y, b_z;
    assign {rp_z, rp_y, rp_x} = p_rdata;
    assign {c_z, c_y, c_x}    = cand_reg;
    assign {b_z, b_y, b_x}    = best_pt_reg;

    logic pt_ok;
    assign pt_ok = (VW'(rp_x) + VW'(l_reg) <= cl_v) &&
                   (VW'(rp_y) + VW'(w_reg) <= cw_v) &&
                   (VW'(rp_z) + VW'(h_reg) <= ch_v) &&
                   (!found_reg || (p_rdata < best_pt_reg));

    // corner row and z bits
    logic [CW-1:0] cn_x, cn_y, c_z1;
    logic          corner_hit;
    assign cn_x  = k_reg[1] ? CW'(c_x + l_reg - 1'b1) : c_x;
    assign cn_y  = k_reg[0] ? CW'(c_y + w_reg - 1'b1) : c_y;
    assign c_z1  = CW'(c_z + h_reg - 1'b1);
    assign corner_hit = g_rdata[c_z[ZI-1:0]] | g_rdata[c_z1[ZI-1:0]];

    logic [CW-1:0] x_end, y_end;
    assign x_end = CW'(b_x + l_reg - 1'b1);
    assign y_end = CW'(b_y + w_reg - 1'b1);

    // RAM control
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = RAW'(fi_reg * GRID_DIM + fj_reg);
        g_wdata = g_rdata | mask_reg;
        g_raddr = RAW'(fi_reg * GRID_DIM + fj_reg);
        p_we    = 1'b0;
        p_waddr = PIW'(count_reg - 1'b1);
        p_wdata = '0;
        p_raddr = PIW'(j_reg);
        case (state_reg)
            S_CLR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_idx_reg;
                g_wdata = '0;
                p_we    = (clr_idx_reg == '0);
                p_waddr = '0;
            end
            S_CN_RD:   g_raddr = RAW'(cn_x * GRID_DIM + cn_y);
            S_FL_WR:   g_we = 1'b1;
            S_MV_RD:   p_raddr = PIW'(count_reg - 1'b1);
            S_MV_CP:
            begin
                p_we    = 1'b1;
                p_waddr = best_idx_reg;
                p_wdata = p_rdata;
            end
            S_W1:
            begin
                p_we    = 1'b1;
                p_wdata = {b_z, b_y, CW'(b_x + l_reg)};
            end
            S_W2:
            begin
                p_we    = 1'b1;
                p_waddr = PIW'(count_reg);
                p_wdata = {b_z, CW'(b_y + w_reg), b_x};
            end
            S_W3:
            begin
                p_we    = 1'b1;
                p_waddr = PIW'(count_reg + 1'b1);
                p_wdata = {CW'(b_z + h_reg), b_y, b_x};
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= epb_pkg::CONTAINER_RESET;
            cfg_wid_reg <= epb_pkg::CONTAINER_RESET;
            cfg_hgt_reg <= epb_pkg::CONTAINER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epb_pkg::REG_LENGTH: cfg_len_reg <= cfg_data;
                epb_pkg::REG_WIDTH:  cfg_wid_reg <= cfg_data;
                epb_pkg::REG_HEIGHT: cfg_hgt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            rst_pass_reg   <= 1'b1;
            clr_idx_reg    <= '0;
            count_reg      <= PCW'(1);
            filled_reg     <= '0;
            found_reg      <= 1'b0;
            j_reg          <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= epb_pkg::ST_OK;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == LAST_ROW)
                    begin
                        clr_idx_reg    <= '0;
                        count_reg      <= PCW'(1);
                        filled_reg     <= '0;
                        found_reg      <= 1'b0;
                        res_status_reg <= epb_pkg::ST_OK;
                        rst_pass_reg   <= 1'b0;
                        state_reg      <= rst_pass_reg ? S_IDLE : S_DONE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        l_reg     <= CW'(req.box_length);
                        w_reg     <= CW'(req.box_width);
                        h_reg     <= CW'(req.box_height);
                        found_reg <= 1'b0;
                        j_reg     <= '0;
                        if (req.operation == epb_pkg::OP_CLEAR)
                        begin
                            state_reg <= S_CLR;
                        end
                        else if (too_large)
                        begin
                            res_status_reg <= epb_pkg::ST_TOO_LARGE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_PT_RD;
                        end
                    end
                end
                S_PT_RD:
                begin
                    state_reg <= (j_reg == count_reg) ? S_DECIDE : S_PT_EVAL;
                end
                S_PT_EVAL:
                begin
                    cand_reg <= p_rdata;
                    k_reg    <= '0;
                    if (pt_ok)
                    begin
                        state_reg <= S_CN_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PT_RD;
                    end
                end
                S_CN_RD:   state_reg <= S_CN_CHK;
                S_CN_CHK:
                begin
                    if (corner_hit || k_reg == 2'd3)
                    begin
                        if (!corner_hit)
                        begin
                            found_reg    <= 1'b1;
                            best_idx_reg <= PIW'(j_reg);
                            best_pt_reg  <= cand_reg;
                        end
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PT_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_CN_RD;
                    end
                end
                S_DECIDE:
                begin
                    fi_reg   <= b_x;
                    fj_reg   <= b_y;
                    mask_reg <= ({GRID_DIM{1'b1}} >> (GRID_DIM - int'(h_reg)))
                                << b_z[ZI-1:0];
                    if (!found_reg)
                    begin
                        res_status_reg <= epb_pkg::ST_NO_FIT;
                        state_reg      <= S_DONE;
                    end
                    else if ((VW'(count_reg) + VW'(2)) > VW'(MAX_POINTS))
                    begin
                        res_status_reg <= epb_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_FL_RD;
                    end
                end
                S_FL_RD:   state_reg <= S_FL_WR;
                S_FL_WR:
                begin
                    // count voxels newly set in this row
                    filled_reg <= filled_reg + FW'($countones(mask_reg & ~g_rdata));
                    state_reg  <= S_FL_RD;
                    if (fj_reg == y_end)
                    begin
                        fj_reg <= b_y;
                        fi_reg <= fi_reg + 1'b1;
                        if (fi_reg == x_end)
                        begin
                            state_reg <= S_MV_RD;
                        end
                    end
                    else
                    begin
                        fj_reg <= fj_reg + 1'b1;
                    end
                end
                S_MV_RD:   state_reg <= S_MV_CP;
                S_MV_CP:   state_reg <= S_W1;
                S_W1:      state_reg <= S_W2;
                S_W2:      state_reg <= S_W3;
                S_W3:
                begin
                    count_reg      <= count_reg + PCW'(2);
                    res_status_reg <= epb_pkg::ST_OK;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_fill_reg   <= epb_pkg::FILL_W'(filled_reg);
                        if (res_status_reg == epb_pkg::ST_OK && found_reg)
                        begin
                            out_x_reg <= epb_pkg::POS_W'(b_x);
                            out_y_reg <= epb_pkg::POS_W'(b_y);
                            out_z_reg <= epb_pkg::POS_W'(b_z);
                        end
                        else
                        begin
                            out_x_reg <= '0;
                            out_y_reg <= '0;
                            out_z_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.pos_x         = out_x_reg;
    assign rsp.pos_y         = out_y_reg;
    assign rsp.pos_z         = out_z_reg;
    assign rsp.filled_voxels = out_fill_reg;

`ifndef SYNTHESIS
    // the point store never overflows and never empties
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (VW'(count_reg) <= VW'(MAX_POINTS)))
        else $error("point count out of range");

    // the filled count never passes the grid size
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        FW'(filled_reg) <= FW'(GRID_DIM * GRID_DIM * GRID_DIM))
        else $error("filled count beyond grid");

    // a placement only proceeds past the decision with a found point
    a_fill_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FL_RD) |-> found_reg)
        else $error("fill without a chosen point");

    // a request taken while idle always moves the sequencer out of idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted request left sequencer idle");
`endif

endmodule
`default_nettype wire

// ----- sim/epb_placer_checker.sv -----
`timescale 1ns / 1ps
// Checker for the extreme-point box placer: predicts each result from observed
// request transfers and config writes, then compares result transfers in order.
// Depends on epb_pkg and the channel interfaces epb_req_if / epb_rsp_if.
module epb_placer_checker #(
    parameter int GRID_DIM   = 64,
    parameter int MAX_POINTS = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [epb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [epb_pkg::DIM_W-1:0]     cfg_data,
    epb_req_if.sink                            req,
    epb_rsp_if.sink                            rsp,
    output int                                 outstanding,
    output int                                 errors
);

    typedef struct {
        epb_pkg::status_t           status;
        logic [epb_pkg::POS_W-1:0]  pos_x;
        logic [epb_pkg::POS_W-1:0]  pos_y;
        logic [epb_pkg::POS_W-1:0]  pos_z;
        logic [epb_pkg::FILL_W-1:0] filled;
    } placement_t;

    placement_t placements_due[$];

    // model state
    bit        occ [GRID_DIM*GRID_DIM*GRID_DIM];
    int        pt_x [MAX_POINTS+2];
    int        pt_y [MAX_POINTS+2];
    int        pt_z [MAX_POINTS+2];
    int        pt_count;
    int        filled_cnt;
    logic [epb_pkg::DIM_W-1:0] cont_len, cont_wid, cont_hgt;

    function automatic int vox(int x, int y, int z);
        return (x * GRID_DIM + y) * GRID_DIM + z;
    endfunction

    function automatic int clamp(logic [epb_pkg::DIM_W-1:0] v);
        return (int'(v) > GRID_DIM) ? GRID_DIM : int'(v);
    endfunction

    task automatic wipe_grid();
        foreach (occ[i]) occ[i] = 1'b0;
        pt_x[0] = 0; pt_y[0] = 0; pt_z[0] = 0;
        pt_count = 1;
        filled_cnt = 0;
    endtask

    function automatic bit corners_clear(int x, int y, int z, int l, int w, int h);
        int xs [2];
        int ys [2];
        int zs [2];
        xs[0] = x; xs[1] = x + l - 1;
        ys[0] = y; ys[1] = y + w - 1;
        zs[0] = z; zs[1] = z + h - 1;
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
                for (int c = 0; c < 2; c++)
                    if (occ[vox(xs[a], ys[b], zs[c])]) return 1'b0;
        return 1'b1;
    endfunction

    // first-fit placement over the stored extreme points
    task automatic place_box(input epb_pkg::op_t op, input int l, input int w,
                             input int h, output placement_t res);
        int cl, cw, ch, best, key, best_key, cx, cy, cz;
        bit found;
        cl = clamp(cont_len);
        cw = clamp(cont_wid);
        ch = clamp(cont_hgt);
        res = '{epb_pkg::ST_OK, '0, '0, '0, '0};
        found = 1'b0;
        best = 0;
        best_key = 0;
        if (op == epb_pkg::OP_CLEAR) begin
            wipe_grid();
        end else if (l == 0 || w == 0 || h == 0 || l > cl || w > cw || h > ch) begin
            res.status = epb_pkg::ST_TOO_LARGE;
        end else begin
            for (int j = 0; j < pt_count && j < MAX_POINTS; j++) begin
                if (pt_x[j] + l > cl || pt_y[j] + w > cw || pt_z[j] + h > ch)
                    continue;
                key = (pt_z[j] << 20) | (pt_y[j] << 10) | pt_x[j];
                if (found && key >= best_key) continue;
                if (!corners_clear(pt_x[j], pt_y[j], pt_z[j], l, w, h)) continue;
                found = 1'b1;
                best = j;
                best_key = key;
            end
            if (!found) begin
                res.status = epb_pkg::ST_NO_FIT;
            end else if (pt_count + 2 > MAX_POINTS) begin
                res.status = epb_pkg::ST_FULL;
            end else begin
                cx = pt_x[best]; cy = pt_y[best]; cz = pt_z[best];
                for (int i = cx; i < cx + l; i++)
                    for (int j = cy; j < cy + w; j++)
                        for (int k = cz; k < cz + h; k++)
                            if (!occ[vox(i, j, k)]) begin
                                occ[vox(i, j, k)] = 1'b1;
                                filled_cnt++;
                            end
                // chosen point replaced by the last, then three new points
                pt_x[best] = pt_x[pt_count-1];
                pt_y[best] = pt_y[pt_count-1];
                pt_z[best] = pt_z[pt_count-1];
                pt_count--;
                pt_x[pt_count] = cx + l; pt_y[pt_count] = cy; pt_z[pt_count] = cz;
                pt_count++;
                pt_x[pt_count] = cx; pt_y[pt_count] = cy + w; pt_z[pt_count] = cz;
                pt_count++;
                pt_x[pt_count] = cx; pt_y[pt_count] = cy; pt_z[pt_count] = cz + h;
                pt_count++;
                res.pos_x = cx[epb_pkg::POS_W-1:0];
                res.pos_y = cy[epb_pkg::POS_W-1:0];
                res.pos_z = cz[epb_pkg::POS_W-1:0];
            end
        end
        res.filled = filled_cnt[epb_pkg::FILL_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n) begin
        placement_t got, want;
        if (!rst_n) begin
            cont_len = epb_pkg::CONTAINER_RESET;
            cont_wid = epb_pkg::CONTAINER_RESET;
            cont_hgt = epb_pkg::CONTAINER_RESET;
            wipe_grid();
            placements_due.delete();
            outstanding = 0;
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    epb_pkg::REG_LENGTH: cont_len = cfg_data;
                    epb_pkg::REG_WIDTH:  cont_wid = cfg_data;
                    epb_pkg::REG_HEIGHT: cont_hgt = cfg_data;
                    default: ;
                endcase
            end
            // result transfer: compare against the oldest prediction
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.filled_voxels};
                if (placements_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %p", $time, got);
                    errors++;
                end else begin
                    want = placements_due.pop_front();
                    if (got.status !== want.status || got.pos_x !== want.pos_x ||
                        got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
                        got.filled !== want.filled) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            // request transfer: predict its result
            if (req.valid && req.ready) begin
                place_box(req.operation, int'(req.box_length), int'(req.box_width),
                          int'(req.box_height), want);
                placements_due = {placements_due, want};
            end
            outstanding = placements_due.size();
        end
    end
endmodule

// ----- sim/extreme_point_box_placer_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the extreme-point box placer: drives requests, config writes
// and result backpressure; checking is done by epb_placer_checker.
// Depends on epb_pkg, epb_if and the placer top level.
module extreme_point_box_placer_unit_tb;

    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam int     HOLD_CYCLES = 3000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [epb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [epb_pkg::DIM_W-1:0]     cfg_data;
    int                            outstanding;
    int                            errors;
    int                            send_idle_pct;
    int                            stall_pct;
    int                            hold_cnt;
    bit                            hold_go;
    longint                        cycles;

    epb_req_if req ();
    epb_rsp_if rsp ();

    extreme_point_box_placer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    epb_placer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req.sink),
        .rsp         (rsp.sink),
        .outstanding (outstanding),
        .errors      (errors)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp.ready <= 1'b0;
        end
        else if (hold_go)
        begin
            hold_go = 1'b0;
            hold_cnt = HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_box(input epb_pkg::op_t op, input int l, input int w,
                            input int h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.box_length <= l[epb_pkg::DIM_W-1:0];
        req.box_width  <= w[epb_pkg::DIM_W-1:0];
        req.box_height <= h[epb_pkg::DIM_W-1:0];
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // container write while idle
    task automatic set_container(input int l, input int w, input int h);
        drain();
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= (i == 0) ? epb_pkg::REG_LENGTH :
                         (i == 1) ? epb_pkg::REG_WIDTH : epb_pkg::REG_HEIGHT;
            cfg_data  <= (i == 0) ? l[epb_pkg::DIM_W-1:0] :
                         (i == 1) ? w[epb_pkg::DIM_W-1:0] : h[epb_pkg::DIM_W-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_extent();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 4);
        if (r < 92) return $urandom_range(1, 16);
        return $urandom_range(0, 127);
    endfunction

    task automatic random_boxes(input int count);
        for (int n = 0; n < count; n++)
            if ($urandom_range(99) < 4)
                send_box(epb_pkg::OP_CLEAR, $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 127));
            else
                send_box(epb_pkg::OP_PLACE, pick_extent(), pick_extent(),
                         pick_extent());
    endtask

    initial
    begin
        int dim;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = epb_pkg::REG_LENGTH;
        cfg_data = '0;
        req.valid = 1'b0;
        req.operation = epb_pkg::OP_CLEAR;
        req.box_length = '0;
        req.box_width = '0;
        req.box_height = '0;
        rsp.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cnt = 0;
        hold_go = 1'b0;
        cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero extents, full grid, clamped and tiny containers
        send_box(epb_pkg::OP_PLACE, 1, 1, 1);
        send_box(epb_pkg::OP_PLACE, 0, 5, 5);
        send_box(epb_pkg::OP_PLACE, 5, 0, 5);
        send_box(epb_pkg::OP_PLACE, 5, 5, 0);
        send_box(epb_pkg::OP_PLACE, 127, 1, 1);
        send_box(epb_pkg::OP_PLACE, 65, 64, 64);
        send_box(epb_pkg::OP_PLACE, 2, 2, 2);
        send_box(epb_pkg::OP_CLEAR, 127, 127, 127);
        send_box(epb_pkg::OP_PLACE, 64, 64, 64);
        send_box(epb_pkg::OP_PLACE, 1, 1, 1);
        send_box(epb_pkg::OP_CLEAR, 0, 0, 0);
        send_box(epb_pkg::OP_PLACE, 3, 3, 3);
        send_box(epb_pkg::OP_PLACE, 4, 2, 2);
        set_container(127, 127, 127);
        send_box(epb_pkg::OP_PLACE, 64, 1, 1);
        send_box(epb_pkg::OP_PLACE, 1, 64, 1);
        set_container(0, 0, 0);
        send_box(epb_pkg::OP_PLACE, 1, 1, 1);
        set_container(1, 1, 1);
        send_box(epb_pkg::OP_CLEAR, 1, 1, 1);
        send_box(epb_pkg::OP_PLACE, 1, 1, 1);
        send_box(epb_pkg::OP_PLACE, 1, 1, 1);
        send_box(epb_pkg::OP_PLACE, 2, 1, 1);

        // random phases, each setting its container and idle mix first
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            case (ph)
                0: set_container(64, 64, 64);
                3: set_container(127, 64, 100);
                5: set_container(8, 8, 8);
                default:
                begin
                    dim = $urandom_range(1, 64);
                    set_container(dim, $urandom_range(1, 127), $urandom_range(4, 64));
                end
            endcase
            send_box(epb_pkg::OP_CLEAR, 0, 0, 0);
            if (ph == 2)
            begin
                // long receiver hold-off while requests keep coming
                hold_go = 1'b1;
                send_idle_pct = 0;
                random_boxes(12);
                send_idle_pct = 0;
            end
            random_boxes(70);
        end
        set_container(64, 64, 64);

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/epb_pkg.sv
hdl/epb_if.sv
hdl/epb_ram.sv
hdl/extreme_point_box_placer_unit.sv
sim/epb_placer_checker.sv
sim/extreme_point_box_placer_unit_tb.sv
